@@ design/sbd_pkg.sv @@
// Shared constants, register indexes and the pipeline control struct of the
// sub-band beat detector. No dependencies.
package sbd_pkg;

  // Default geometry of the detector.
  localparam int NUM_BANDS_DEF     = 32;
  localparam int BINS_PER_BAND_DEF = 32;
  localparam int HISTORY_LEN_DEF   = 43;

  // Fixed field widths.
  localparam int MAG_W    = 16;
  localparam int ENERGY_W = 16;
  localparam int FRAME_W  = 32;
  localparam int VOTE_W   = 6;
  localparam int THR_W    = 6;
  localparam int REFR_W   = 8;

  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESHOLD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_FRAMES = 1'd1;

  localparam logic [THR_W-1:0]  VOTE_THR_RST = 6'd31;
  localparam logic [REFR_W-1:0] REFR_RST     = 8'd30;

  // Control carried alongside each pipeline event.
  typedef struct packed {
    logic               vld;          // event present
    logic               close;        // a band closes with this event
    logic               last;         // frame ends with this event
    logic               emit;         // frame end gives a result
    logic               full;         // history window full before this frame
    logic [FRAME_W-1:0] frame_number;
  } sbd_ctl_t;

endpackage

@@ design/sbd_if.sv @@
// Stream interfaces of the beat detector: spectrum bins in, beat results out.
// Depends on sbd_pkg.
interface sbd_bin_if;
  import sbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [MAG_W-1:0]   left_mag;
  logic [MAG_W-1:0]   right_mag;
  logic [FRAME_W-1:0] frame_number;
  logic               last_bin;

  modport source (output valid, left_mag, right_mag, frame_number, last_bin, input ready);
  modport sink   (input valid, left_mag, right_mag, frame_number, last_bin, output ready);
endinterface

interface sbd_res_if;
  import sbd_pkg::*;

  logic              valid;
  logic              ready;
  logic              beat;
  logic [VOTE_W-1:0] votes;

  modport source (output valid, beat, votes, input ready);
  modport sink   (input valid, beat, votes, output ready);
endinterface

@@ design/sbd_front.sv @@
// Front end: bin position tracking, band accumulation and frame bookkeeping.
// Emits one event per band close or frame end. Depends on sbd_pkg, sbd_if.
module sbd_front #(
  parameter int NUM_BANDS     = sbd_pkg::NUM_BANDS_DEF,
  parameter int BINS_PER_BAND = sbd_pkg::BINS_PER_BAND_DEF,
  parameter int HISTORY_LEN   = sbd_pkg::HISTORY_LEN_DEF,
  localparam int BAND_W  = $clog2(NUM_BANDS),
  localparam int ACC_W   = $clog2(2 * BINS_PER_BAND) + sbd_pkg::MAG_W,
  localparam int HADDR_W = $clog2(NUM_BANDS * HISTORY_LEN)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  sbd_bin_if.sink              bins_i,
  output sbd_pkg::sbd_ctl_t    s1_ctl_o,
  output logic [ACC_W-1:0]     s1_acc_o,
  output logic [BAND_W-1:0]    s1_band_o,
  output logic [HADDR_W-1:0]   s1_haddr_o
);
  import sbd_pkg::*;

  localparam int POS_W   = $clog2(BINS_PER_BAND);
  localparam int BANDC_W = $clog2(NUM_BANDS + 1);
  localparam int SLOT_W  = $clog2(HISTORY_LEN);
  localparam int FILL_W  = $clog2(HISTORY_LEN + 1);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BANDC_W-1:0] band_q, band_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  logic               accept, in_range, band_end, close, full;
  logic [ACC_W-1:0]   acc_sum;
  logic [FILL_W-1:0]  fill_inc;
  logic [HADDR_W-1:0] haddr;
  sbd_ctl_t           ctl_d, ctl_q;
  logic [ACC_W-1:0]   acc_out_q;
  logic [BAND_W-1:0]  band_out_q;
  logic [HADDR_W-1:0] haddr_out_q;

  assign bins_i.ready = adv_i;
  assign accept       = bins_i.valid && adv_i;

  assign in_range = band_q < BANDC_W'(NUM_BANDS);
  assign band_end = pos_q == POS_W'(BINS_PER_BAND - 1);
  assign close    = in_range && (band_end || bins_i.last_bin);
  assign acc_sum  = acc_q + ACC_W'(bins_i.left_mag) + ACC_W'(bins_i.right_mag);
  assign full     = fill_q == FILL_W'(HISTORY_LEN);
  assign fill_inc = full ? fill_q : fill_q + 1'b1;
  assign haddr    = HADDR_W'(band_q[BAND_W-1:0]) * HADDR_W'(HISTORY_LEN) + HADDR_W'(slot_q);

  always_comb begin
    pos_d  = pos_q;
    band_d = band_q;
    acc_d  = acc_q;
    fill_d = fill_q;
    slot_d = slot_q;
    if (accept) begin
      if (bins_i.last_bin) begin
        pos_d  = '0;
        band_d = '0;
        acc_d  = '0;
        fill_d = fill_inc;
        slot_d = (slot_q == SLOT_W'(HISTORY_LEN - 1)) ? '0 : slot_q + 1'b1;
      end else if (in_range) begin
        acc_d = close ? '0 : acc_sum;
        if (band_end) begin
          pos_d  = '0;
          band_d = band_q + 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ctl_d.vld          = accept && (close || bins_i.last_bin);
    ctl_d.close        = close;
    ctl_d.last         = bins_i.last_bin;
    ctl_d.emit         = bins_i.last_bin && (fill_inc == FILL_W'(HISTORY_LEN));
    ctl_d.full         = full;
    ctl_d.frame_number = bins_i.frame_number;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      band_q <= '0;
      acc_q  <= '0;
      fill_q <= '0;
      slot_q <= '0;
      ctl_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      band_q <= band_d;
      acc_q  <= acc_d;
      fill_q <= fill_d;
      slot_q <= slot_d;
      if (adv_i) begin
        ctl_q <= ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_out_q   <= acc_sum;
      band_out_q  <= band_q[BAND_W-1:0];
      haddr_out_q <= haddr;
    end
  end

  assign s1_ctl_o   = ctl_q;
  assign s1_acc_o   = acc_out_q;
  assign s1_band_o  = band_out_q;
  assign s1_haddr_o = haddr_out_q;

`ifndef SYNTHESIS
  // Slot and fill count move in step until the window is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> slot_q == SLOT_W'(fill_q))
    else $error("history slot out of step with fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_q <= BANDC_W'(NUM_BANDS))
    else $error("band index ran past the last band");
`endif

endmodule

@@ design/sbd_band.sv @@
// Band update: energy by reciprocal multiply, history and window-sum memories
// with read-modify-write and sum forwarding. Depends on sbd_pkg.
module sbd_band #(
  parameter int NUM_BANDS     = sbd_pkg::NUM_BANDS_DEF,
  parameter int BINS_PER_BAND = sbd_pkg::BINS_PER_BAND_DEF,
  parameter int HISTORY_LEN   = sbd_pkg::HISTORY_LEN_DEF,
  localparam int BAND_W  = $clog2(NUM_BANDS),
  localparam int ACC_W   = $clog2(2 * BINS_PER_BAND) + sbd_pkg::MAG_W,
  localparam int HADDR_W = $clog2(NUM_BANDS * HISTORY_LEN),
  localparam int SUM_W   = sbd_pkg::ENERGY_W + $clog2(HISTORY_LEN)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  sbd_pkg::sbd_ctl_t    s1_ctl_i,
  input  logic [ACC_W-1:0]     s1_acc_i,
  input  logic [BAND_W-1:0]    s1_band_i,
  input  logic [HADDR_W-1:0]   s1_haddr_i,
  output sbd_pkg::sbd_ctl_t    s3_ctl_o,
  output logic [SUM_W-1:0]     s3_sum_o,
  output logic [SUM_W-1:0]     s3_ehl_o
);
  import sbd_pkg::*;

  // floor(acc / (2*BINS_PER_BAND)) = (acc * RECIP) >> SHIFT, exact for acc < 2^ACC_W.
  localparam int DIV    = 2 * BINS_PER_BAND;
  localparam int DIV_L  = $clog2(DIV);
  localparam int SHIFT  = ACC_W + DIV_L;
  localparam int MULT_W = ACC_W + 1;
  localparam int PROD_W = ACC_W + MULT_W;
  localparam longint unsigned RECIP = (longint'(1) << SHIFT) / DIV + 1;
  localparam logic [MULT_W-1:0] RECIP_M = MULT_W'(RECIP);
  localparam int HIST_DEPTH = NUM_BANDS * HISTORY_LEN;

  logic [ENERGY_W-1:0] hist_mem [HIST_DEPTH];
  logic [SUM_W-1:0]    sum_mem  [NUM_BANDS];
  logic [NUM_BANDS-1:0] sum_vld_q;

  sbd_ctl_t            s2_ctl_q, s3_ctl_q;
  logic [BAND_W-1:0]   s2_band_q, s3_band_q;
  logic [HADDR_W-1:0]  s2_haddr_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ENERGY_W-1:0] hist_rd_q;
  logic [SUM_W-1:0]    sum_rd_q;
  logic                sum_vld_rd_q;
  logic [SUM_W-1:0]    s3_sum_q, s3_ehl_q;

  logic [ENERGY_W-1:0] energy;
  logic [SUM_W-1:0]    old_val, base_sum, new_sum, ehl;
  logic                wr, fwd;

  assign energy   = prod_q[SHIFT +: ENERGY_W];
  assign old_val  = s2_ctl_q.full ? SUM_W'(hist_rd_q) : '0;
  // The event one stage ahead may have just written this band's sum.
  assign fwd      = s3_ctl_q.vld && s3_ctl_q.close && (s3_band_q == s2_band_q);
  assign base_sum = fwd ? s3_sum_q : (sum_vld_rd_q ? sum_rd_q : '0);
  assign new_sum  = base_sum - old_val + SUM_W'(energy);
  assign ehl      = SUM_W'(HISTORY_LEN) * SUM_W'(energy);
  assign wr       = adv_i && s2_ctl_q.vld && s2_ctl_q.close;

  // Read port and stage two payload.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hist_rd_q    <= hist_mem[s1_haddr_i];
      sum_rd_q     <= sum_mem[s1_band_i];
      sum_vld_rd_q <= sum_vld_q[s1_band_i];
      prod_q       <= PROD_W'(s1_acc_i) * PROD_W'(RECIP_M);
      s2_band_q    <= s1_band_i;
      s2_haddr_q   <= s1_haddr_i;
    end
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      hist_mem[s2_haddr_q] <= energy;
      sum_mem[s2_band_q]   <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= '0;
      s2_ctl_q  <= '0;
      s3_ctl_q  <= '0;
    end else begin
      if (wr) begin
        sum_vld_q[s2_band_q] <= 1'b1;
      end
      if (adv_i) begin
        s2_ctl_q <= s1_ctl_i;
        s3_ctl_q <= s2_ctl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_band_q <= s2_band_q;
      s3_sum_q  <= new_sum;
      s3_ehl_q  <= ehl;
    end
  end

  assign s3_ctl_o = s3_ctl_q;
  assign s3_sum_o = s3_sum_q;
  assign s3_ehl_o = s3_ehl_q;

`ifndef SYNTHESIS
  // A history entry is never read while the event just ahead writes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_ctl_i.vld && s1_ctl_i.close && s2_ctl_q.vld && s2_ctl_q.close)
      |-> s1_haddr_i != s2_haddr_q)
    else $error("history read collides with pending write");
`endif

endmodule

@@ design/sbd_vote.sv @@
// Vote counting, beat decision with refractory gap, configuration registers
// and the result output register. Depends on sbd_pkg, sbd_if.
module sbd_vote #(
  parameter int NUM_BANDS   = sbd_pkg::NUM_BANDS_DEF,
  parameter int HISTORY_LEN = sbd_pkg::HISTORY_LEN_DEF,
  localparam int SUM_W = sbd_pkg::ENERGY_W + $clog2(HISTORY_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbd_pkg::sbd_ctl_t                 s3_ctl_i,
  input  logic [SUM_W-1:0]                  s3_sum_i,
  input  logic [SUM_W-1:0]                  s3_ehl_i,
  input  logic                              cfg_we_i,
  input  logic [sbd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sbd_res_if.source                         results_o,
  output logic                              adv_o
);
  import sbd_pkg::*;

  logic [THR_W-1:0]   thr_q;
  logic [REFR_W-1:0]  refr_q;
  logic [VOTE_W-1:0]  cnt_q, cnt_plus;
  logic [FRAME_W-1:0] last_beat_q;
  logic               out_vld_q, out_beat_q;
  logic [VOTE_W-1:0]  out_votes_q;
  logic               vote, emit, fire, beat;

  assign vote     = s3_ctl_i.vld && s3_ctl_i.close && (s3_ehl_i > s3_sum_i);
  assign cnt_plus = (vote && cnt_q != VOTE_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign emit     = s3_ctl_i.vld && s3_ctl_i.last && s3_ctl_i.emit;
  // Hold the pipeline only when a new result would land on a waiting one.
  assign adv_o    = !(emit && out_vld_q && !results_o.ready);
  assign fire     = adv_o && emit;
  assign beat     = (cnt_plus >= VOTE_W'(thr_q)) &&
                    ((s3_ctl_i.frame_number - last_beat_q) > FRAME_W'(refr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= VOTE_THR_RST;
      refr_q <= REFR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VOTE_THRESHOLD:    thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_REFRACTORY_FRAMES: refr_q <= cfg_data_i[REFR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_beat_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (adv_o && s3_ctl_i.vld) begin
        cnt_q <= s3_ctl_i.last ? '0 : cnt_plus;
      end
      if (fire && beat) begin
        last_beat_q <= s3_ctl_i.frame_number;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (results_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_beat_q  <= beat;
      out_votes_q <= cnt_plus;
    end
  end

  assign results_o.valid = out_vld_q;
  assign results_o.beat  = out_beat_q;
  assign results_o.votes = out_votes_q;

`ifndef SYNTHESIS
  // Each band closes at most once per frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= NUM_BANDS)
    else $error("vote count exceeds band count");

  // A result never overwrites one still waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !results_o.ready) |-> !fire)
    else $error("waiting result overwritten");
`endif

endmodule

@@ design/subband_beat_detector.sv @@
// Top level of the sub-band beat detector: front end, band update, voting.
// Depends on sbd_pkg, sbd_if, sbd_front, sbd_band, sbd_vote.
//
// Usage:
//   bins_i carries one spectrum bin per item: left and right magnitudes
//   (unsigned Q0.16), the frame number and a last_bin flag closing the frame.
//   Bins are grouped NUM_BANDS x BINS_PER_BAND per frame; each band's average
//   energy enters a HISTORY_LEN deep window held in block memory.
//   results_o carries one item per frame end once the window is full: the
//   vote count and a beat flag. Other bins produce no result.
//   Throughput: one bin per cycle, sustained while input ready holds (Stall),
//   including back-to-back frame ends. The rate is set by the history/sum
//   memories, one read and one write port each, touched once per band close.
//   Result path: the event of an accepted last_bin bin passes the accumulate,
//   multiply/read and update stages, then the vote sets the result register.
//   Reset: counters, fill state, per-band sum valid flags and config registers
//   clear at once; sums are gated by those flags, so no clearing pass is run.
//   Stall: bins keep flowing while a result waits on results_o; input ready
//   drops only when a new result would overwrite a waiting one.
//   Config: cfg_we_i writes register cfg_idx_i (0 = vote threshold,
//   1 = refractory frames) from cfg_data_i; write only while idle.
module subband_beat_detector #(
  parameter int NUM_BANDS     = sbd_pkg::NUM_BANDS_DEF,
  parameter int BINS_PER_BAND = sbd_pkg::BINS_PER_BAND_DEF,
  parameter int HISTORY_LEN   = sbd_pkg::HISTORY_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sbd_bin_if.sink                        bins_i,
  sbd_res_if.source                      results_o,
  input  logic                           cfg_we_i,
  input  logic [sbd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sbd_pkg::*;

  localparam int BAND_W  = $clog2(NUM_BANDS);
  localparam int ACC_W   = $clog2(2 * BINS_PER_BAND) + MAG_W;
  localparam int HADDR_W = $clog2(NUM_BANDS * HISTORY_LEN);
  localparam int SUM_W   = ENERGY_W + $clog2(HISTORY_LEN);

  // Global advance: the whole pipeline moves together.
  logic               adv;
  sbd_ctl_t           s1_ctl, s3_ctl;
  logic [ACC_W-1:0]   s1_acc;
  logic [BAND_W-1:0]  s1_band;
  logic [HADDR_W-1:0] s1_haddr;
  logic [SUM_W-1:0]   s3_sum, s3_ehl;

  // Stage 0: count bins, accumulate L+R, issue band-close / frame-end events.
  sbd_front #(
    .NUM_BANDS    (NUM_BANDS),
    .BINS_PER_BAND(BINS_PER_BAND),
    .HISTORY_LEN  (HISTORY_LEN)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .bins_i    (bins_i),
    .s1_ctl_o  (s1_ctl),
    .s1_acc_o  (s1_acc),
    .s1_band_o (s1_band),
    .s1_haddr_o(s1_haddr)
  );

  // Stages 1-2: energy, memory read, window-sum update and write-back.
  sbd_band #(
    .NUM_BANDS    (NUM_BANDS),
    .BINS_PER_BAND(BINS_PER_BAND),
    .HISTORY_LEN  (HISTORY_LEN)
  ) u_band (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .s1_ctl_i  (s1_ctl),
    .s1_acc_i  (s1_acc),
    .s1_band_i (s1_band),
    .s1_haddr_i(s1_haddr),
    .s3_ctl_o  (s3_ctl),
    .s3_sum_o  (s3_sum),
    .s3_ehl_o  (s3_ehl)
  );

  // Stage 3: count votes, decide the beat, drive the result register.
  sbd_vote #(
    .NUM_BANDS  (NUM_BANDS),
    .HISTORY_LEN(HISTORY_LEN)
  ) u_vote (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s3_ctl_i  (s3_ctl),
    .s3_sum_i  (s3_sum),
    .s3_ehl_i  (s3_ehl),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .results_o (results_o),
    .adv_o     (adv)
  );

endmodule

@@ test/tb_subband_beat_detector.sv @@
// Self-checking testbench of the sub-band beat detector: streams spectrum bins, predicts
// votes and beats per frame, and checks every result item. Depends on sbd_pkg, sbd_if
// and the subband_beat_detector top level.
module tb_subband_beat_detector;
  import sbd_pkg::*;

  localparam int NBANDS     = NUM_BANDS_DEF;
  localparam int BPB        = BINS_PER_BAND_DEF;
  localparam int HLEN       = HISTORY_LEN_DEF;
  localparam int FRAME_BINS = NBANDS * BPB;

  // Run limit, far above the slowest legal run.
  localparam int CYCLE_LIMIT  = 100_000;
  // Slack after the last expected result, so the pipeline can flush.
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [MAG_W-1:0]   left;
    logic [MAG_W-1:0]   right;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } bin_item_t;

  typedef struct packed {
    logic              beat;
    logic [VOTE_W-1:0] votes;
  } beat_res_t;

  // Magnitude character of a frame: drives how bands vote against history.
  typedef enum int {LVL_QUIET, LVL_LOUD, LVL_WIDE, LVL_EDGE} level_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sbd_bin_if bin_bus ();
  sbd_res_if res_bus ();

  subband_beat_detector uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bins_i     (bin_bus),
    .results_o  (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Stimulus and expectation stores.
  bin_item_t   pending_bins[$];
  beat_res_t   expected_beats[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Generation bookkeeping: history slot of the next frame, frames and bins queued,
  // and the largest frame each slot may take once the window is full.
  int unsigned gen_slot = 0;
  int unsigned gen_frames = 0;
  int unsigned gen_bins = 0;
  int unsigned slot_cap [HLEN];

  // Predictor state: a private copy of everything the detector keeps.
  logic [ENERGY_W-1:0] hist_mem [NBANDS*HLEN];
  int unsigned         band_sum [NBANDS];
  int unsigned         bin_acc;
  int unsigned         bin_idx;
  int unsigned         hist_fill;
  int unsigned         hist_slot;
  int unsigned         vote_cnt;
  logic [FRAME_W-1:0]  last_beat;
  logic [THR_W-1:0]    thr_reg;
  logic [REFR_W-1:0]   refr_reg;

  // Advance the predictor by one accepted bin; queue the result of a full-window frame end.
  function automatic void predict_bin(bin_item_t it);
    int unsigned        band;
    int unsigned        energy;
    int unsigned        idx;
    int unsigned        votes;
    logic [FRAME_W-1:0] since_beat;
    beat_res_t          res;
    // Bins past the last band of the frame are dropped; only last_bin still counts.
    if (bin_idx < FRAME_BINS) begin
      band = bin_idx / BPB;
      bin_acc += it.left + it.right;
      // A band closes on its own last bin, or early when the frame ends short.
      if ((bin_idx % BPB) == BPB - 1 || it.last) begin
        energy = bin_acc / (2 * BPB);
        if (energy > 32'h0000_FFFF) energy = 32'h0000_FFFF;
        idx = band * HLEN + hist_slot;
        // Retire the oldest entry of the window once it has filled.
        if (hist_fill >= HLEN) band_sum[band] -= hist_mem[idx];
        hist_mem[idx] = ENERGY_W'(energy);
        band_sum[band] += energy;
        if (HLEN * energy > band_sum[band] && vote_cnt < VOTE_MAX) vote_cnt++;
        bin_acc = 0;
      end
      bin_idx++;
    end
    if (it.last) begin
      if (hist_fill < HLEN) hist_fill++;
      hist_slot = (hist_slot + 1 >= HLEN) ? 0 : hist_slot + 1;
      votes = vote_cnt;
      bin_idx = 0;
      bin_acc = 0;
      vote_cnt = 0;
      if (hist_fill >= HLEN) begin
        // The frame distance wraps modulo 2^32.
        since_beat = it.frame - last_beat;
        res.beat = (votes >= thr_reg) && (since_beat > refr_reg);
        res.votes = VOTE_W'(votes);
        if (res.beat) last_beat = it.frame;
        expected_beats.insert(expected_beats.size(), res);
      end
    end
  endfunction

  function automatic logic [MAG_W-1:0] gen_mag(level_e lvl);
    case (lvl)
      LVL_QUIET: return MAG_W'($urandom_range(0, 255));
      LVL_LOUD:  return MAG_W'($urandom_range(16'hC000, 16'hFFFF));
      LVL_EDGE:  return $urandom_range(0, 1) ? '1 : '0;
      default:   return MAG_W'($urandom);
    endcase
  endfunction

  function automatic void push_bin(logic [MAG_W-1:0] left, logic [MAG_W-1:0] right,
                                   logic [FRAME_W-1:0] frame, logic last);
    bin_item_t it;
    it = '{left: left, right: right, frame: frame, last: last};
    pending_bins.insert(pending_bins.size(), it);
    gen_bins++;
    if (last) begin
      // While the window fills, note how far the frame of each slot reached;
      // later frames of that slot stay within it, so no band retires an
      // entry it never wrote.
      if (gen_frames < HLEN) begin
        slot_cap[gen_slot] = (gen_bins >= FRAME_BINS) ? FRAME_BINS + BPB
                                                      : ((gen_bins + BPB - 1) / BPB) * BPB;
        gen_frames++;
      end
      gen_slot = (gen_slot + 1 >= HLEN) ? 0 : gen_slot + 1;
      gen_bins = 0;
    end
  endfunction

  // Queue one frame of nbins bins; only the final bin carries last_bin and the
  // real frame number, the others get noise in the frame field.
  function automatic void add_frame(int unsigned nbins, level_e lvl, logic [FRAME_W-1:0] fno);
    for (int unsigned k = 0; k < nbins; k++) begin
      if (k == nbins - 1) push_bin(gen_mag(lvl), gen_mag(lvl), fno, 1'b1);
      else push_bin(gen_mag(lvl), gen_mag(lvl), FRAME_W'($urandom), 1'b0);
    end
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  // Write one register; the block is idle whenever this is called.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DATA_W'(value);
    if (idx == CFG_VOTE_THRESHOLD) thr_reg = THR_W'(value);
    else refr_reg = REFR_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued bin is taken and every expected result is back,
  // then let the pipeline flush bins that give no result. Sample between
  // edges so the driver has settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bins.size() != 0 || bin_bus.valid || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Bin driver: present the next queued item unless idling; predict on acceptance.
  always @(posedge clk_i) begin : bin_driver
    bin_item_t took;
    if (rst_ni) begin
      if (bin_bus.valid && bin_bus.ready) begin
        took = '{left: bin_bus.left_mag, right: bin_bus.right_mag,
                 frame: bin_bus.frame_number, last: bin_bus.last_bin};
        predict_bin(took);
      end
      if (!bin_bus.valid || bin_bus.ready) begin
        if (pending_bins.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          took = pending_bins[0];
          pending_bins.delete(0);
          bin_bus.valid <= 1'b1;
          bin_bus.left_mag <= took.left;
          bin_bus.right_mag <= took.right;
          bin_bus.frame_number <= took.frame;
          bin_bus.last_bin <= took.last;
        end else begin
          // Drive noise on the idle payload; it must be ignored.
          bin_bus.valid <= 1'b0;
          bin_bus.left_mag <= MAG_W'($urandom);
          bin_bus.right_mag <= MAG_W'($urandom);
          bin_bus.frame_number <= FRAME_W'($urandom);
          bin_bus.last_bin <= 1'($urandom);
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : res_monitor
    beat_res_t want;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat=%0b votes=%0d",
                                  res_bus.beat, res_bus.votes));
        end else begin
          want = expected_beats[0];
          expected_beats.delete(0);
          if (res_bus.beat !== want.beat)
            flag_mismatch($sformatf("beat expected %0b actual %0b", want.beat, res_bus.beat));
          if (res_bus.votes !== want.votes)
            flag_mismatch($sformatf("votes expected %0d actual %0d", want.votes, res_bus.votes));
        end
      end
      res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] fno;
    int unsigned        phase_items;
    int unsigned        nbins;
    int unsigned        lim;
    // Known levels on every block input before the first edge.
    bin_bus.valid = 1'b0;
    bin_bus.left_mag = '0;
    bin_bus.right_mag = '0;
    bin_bus.frame_number = '0;
    bin_bus.last_bin = 1'b0;
    res_bus.ready = 1'b0;
    // Predictor starts from the reset state.
    bin_acc = 0;
    bin_idx = 0;
    hist_fill = 0;
    hist_slot = 0;
    vote_cnt = 0;
    last_beat = '0;
    thr_reg = VOTE_THR_RST;
    refr_reg = REFR_RST;
    foreach (band_sum[b]) band_sum[b] = 0;
    foreach (slot_cap[s]) slot_cap[s] = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the window with quiet single-bin frames, then end on a loud long
    // frame: every band closes, the extra bins are dropped, and all bands
    // should vote: votes equal to a threshold of 32.
    write_reg(CFG_VOTE_THRESHOLD, 32);
    write_reg(CFG_REFRACTORY_FRAMES, 255);
    fno = 32'd1000;
    for (int f = 0; f < HLEN; f++) begin
      if (f == HLEN - 1) add_frame(FRAME_BINS + $urandom_range(1, 8), LVL_LOUD, fno);
      else add_frame(1, LVL_QUIET, fno);
      fno++;
    end
    wait_idle();

    // Directed frames: threshold zero, no refractory hold-off. Single-bin
    // frames close band zero only; walk the frame number through a repeat,
    // a step of one, and a wrap past 2^32.
    write_reg(CFG_VOTE_THRESHOLD, 0);
    write_reg(CFG_REFRACTORY_FRAMES, 0);
    push_bin('1, '1, fno - 1, 1'b1);
    push_bin('0, '0, fno - 1, 1'b1);
    push_bin('0, '0, fno, 1'b1);
    push_bin('1, '0, 32'hFFFF_FFFF, 1'b1);
    push_bin('0, '1, 32'h0000_0002, 1'b1);
    push_bin('1, '1, 32'h0000_0002, 1'b1);
    push_bin('1, '0, 32'hAAAA_AAAA, 1'b0);
    push_bin('0, '1, 32'h0000_0003, 1'b1);
    push_bin('1, '1, 32'h5555_5555, 1'b0);
    push_bin('1, '1, 32'hFFFF_FFFF, 1'b0);
    push_bin('1, '1, 32'h0000_0000, 1'b1);
    push_bin('0, '0, 32'h0000_0001, 1'b1);
    push_bin('1, '1, 32'h8000_0000, 1'b1);
    push_bin('1, '1, 32'h8000_0000, 1'b1);
    push_bin('1, '1, 32'h8000_0001, 1'b1);
    wait_idle();
    fno = 32'h8000_0002;

    // Random phases, each with its own idling pattern and register setting.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_reg(CFG_VOTE_THRESHOLD, 0);
          write_reg(CFG_REFRACTORY_FRAMES, 255);
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct = 0;
          write_reg(CFG_VOTE_THRESHOLD, $urandom_range(1, 4));
          write_reg(CFG_REFRACTORY_FRAMES, 0);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 87;
          write_reg(CFG_VOTE_THRESHOLD, $urandom_range(0, 3));
          write_reg(CFG_REFRACTORY_FRAMES, $urandom_range(0, 8));
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
          write_reg(CFG_VOTE_THRESHOLD, $urandom_range(1, 2));
          write_reg(CFG_REFRACTORY_FRAMES, $urandom_range(1, 3));
        end
      endcase
      // Short frames, each within what its slot reached while the window filled.
      phase_items = 0;
      while (phase_items < 40) begin
        lim = (slot_cap[gen_slot] > 40) ? 40 : slot_cap[gen_slot];
        nbins = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lim) : $urandom_range(1, 4);
        add_frame(nbins, level_e'($urandom_range(0, 3)), fno);
        phase_items += nbins;
        // Mostly small frame steps, now and then a jump anywhere.
        if ($urandom_range(0, 15) == 0) fno = FRAME_W'($urandom);
        else fno += $urandom_range(0, 3);
      end
      wait_idle();
    end

    if (expected_beats.size() != 0) begin
      mismatches += expected_beats.size();
      $display("mismatch: %0d expected results never arrived", expected_beats.size());
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
